// ===== rtl/hdlc_rx_pkg.sv =====
// ----------------------------------------------------------------------------
// HDLC receiver package
// Shared constants, codes, record types and the CRC-16 byte update.
// ----------------------------------------------------------------------------
package hdlc_rx_pkg;

	// Framing octets
	localparam logic [7:0] FLAG_OCTET    = 8'h7E;
	localparam logic [7:0] ESC_OCTET     = 8'h7D;
	localparam logic [7:0] ESC_XOR       = 8'h20;

	// Stuffed zero: five ones followed by a zero in the newest line bits
	localparam logic [7:0] STUFF_MASK    = 8'hFC;
	localparam logic [7:0] STUFF_PATTERN = 8'h7C;

	// CRC-16, non-reflected, polynomial x^16 + x^12 + x^5 + 1
	localparam logic [15:0] CRC_POLY       = 16'h1021;
	localparam logic [15:0] CRC_INIT_RESET = 16'hFFFF;

	localparam int DEF_MAX_FRAME_BYTES = 1024;
	localparam int LEN_W               = 10;
	localparam int CFG_DATA_W          = 16;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_BIT_MODE       = 2'd0,
		CFG_CRC_BIG_ENDIAN = 2'd1,
		CFG_CRC_INIT       = 2'd2
	} cfg_reg_t;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_END_OK  = 2'd1,
		KIND_END_BAD = 2'd2
	} kind_t;

	// One recovered octet (a flag in bit mode comes through as FLAG_OCTET)
	typedef struct packed {
		logic       valid;
		logic [7:0] value;
	} octet_ev_t;

	// One result request
	typedef struct packed {
		logic             valid;
		kind_t            kind;
		logic [7:0]       payload_byte;
		logic [LEN_W-1:0] frame_length;
		logic             dropped;
	} result_t;

	// Advance the CRC over one octet, MSB first
	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

// ===== rtl/hdlc_rx_if.sv =====
// ----------------------------------------------------------------------------
// HDLC receiver channel interfaces
// Valid/ready channels for line items in and frame results out.
// ----------------------------------------------------------------------------
interface hdlc_rx_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_in;

	modport source (output valid, output data_in, input ready);
	modport sink (input valid, input data_in, output ready);
endinterface

interface hdlc_rx_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  payload_byte;
	logic [9:0]  frame_length;
	logic        dropped;

	modport source (output valid, output kind, output payload_byte, output frame_length,
		output dropped, input ready);
	modport sink (input valid, input kind, input payload_byte, input frame_length,
		input dropped, output ready);
endinterface

// ===== rtl/hdlc_rx_unstuff.sv =====
// ----------------------------------------------------------------------------
// HDLC receiver bit unstuffer
// In bit mode: flag search, zero-bit removal and LSB-first octet packing.
// In byte mode the input byte passes as an octet.
// ----------------------------------------------------------------------------
module hdlc_rx_unstuff (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic                   bit_mode,
	input  logic [7:0]             data,
	output hdlc_rx_pkg::octet_ev_t octet
);

	logic [7:0] recent_q;
	logic [7:0] assembly_q;
	logic [2:0] count_q;

	logic [7:0] recent_next;
	logic [7:0] assembly_shift;
	logic       flag_seen;
	logic       stuffed;

	// Shift the newest line bit in at the top
	always_comb begin
		recent_next    = {data[0], recent_q[7:1]};
		assembly_shift = {data[0], assembly_q[7:1]};
		flag_seen      = (recent_next == hdlc_rx_pkg::FLAG_OCTET);
		stuffed        = ((recent_next & hdlc_rx_pkg::STUFF_MASK) == hdlc_rx_pkg::STUFF_PATTERN);
	end

	// Decide whether this item completes an octet
	always_comb begin
		octet.valid = 1'b0;
		octet.value = data;
		if (!bit_mode) begin
			octet.valid = 1'b1;
		end else if (flag_seen) begin
			octet.valid = 1'b1;
			octet.value = hdlc_rx_pkg::FLAG_OCTET;
		end else if (!stuffed && (count_q == 3'd7)) begin
			octet.valid = 1'b1;
			octet.value = assembly_shift;
		end
	end

	// Hold the bit history and the partial octet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q   <= '0;
			assembly_q <= '0;
			count_q    <= '0;
		end else if (step && bit_mode) begin
			recent_q <= recent_next;
			if (flag_seen) begin
				assembly_q <= '0;
				count_q    <= '0;
			end else if (!stuffed) begin
				if (count_q == 3'd7) begin
					assembly_q <= '0;
					count_q    <= '0;
				end else begin
					assembly_q <= assembly_shift;
					count_q    <= count_q + 3'd1;
				end
			end
		end
	end

endmodule

// ===== rtl/hdlc_rx_frame.sv =====
// ----------------------------------------------------------------------------
// HDLC receiver frame tracker
// Unescapes octets, keeps the two-octet delay line, runs the CRC and
// produces payload and frame-end result requests.
// ----------------------------------------------------------------------------
module hdlc_rx_frame #(
	parameter int MAX_FRAME_BYTES = hdlc_rx_pkg::DEF_MAX_FRAME_BYTES
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic                   crc_big_endian,
	input  logic [15:0]            crc_init,
	input  hdlc_rx_pkg::octet_ev_t octet,
	output hdlc_rx_pkg::result_t   result
);

	localparam int PW = $clog2(MAX_FRAME_BYTES);
	localparam int LW = (PW > hdlc_rx_pkg::LEN_W) ? PW : hdlc_rx_pkg::LEN_W;
	localparam logic [PW-1:0] POS_LAST = PW'(MAX_FRAME_BYTES - 1);

	logic          escape_q;
	logic [PW-1:0] pos_q;
	logic [15:0]   crc_q;
	logic [7:0]    delay0_q;
	logic [7:0]    delay1_q;

	logic          is_flag;
	logic          is_esc;
	logic          pos_ge2;
	logic          at_limit;
	logic [7:0]    ch;
	logic [15:0]   rx_check;
	logic [15:0]   crc_next;
	logic [LW-1:0] len_wide;

	// Classify the octet and form the check values
	always_comb begin
		is_flag  = (octet.value == hdlc_rx_pkg::FLAG_OCTET);
		is_esc   = !escape_q && (octet.value == hdlc_rx_pkg::ESC_OCTET);
		ch       = escape_q ? (octet.value ^ hdlc_rx_pkg::ESC_XOR) : octet.value;
		pos_ge2  = |pos_q[PW-1:1];
		at_limit = (pos_q == POS_LAST);
		rx_check = crc_big_endian ? {delay0_q, delay1_q} : {delay1_q, delay0_q};
		crc_next = hdlc_rx_pkg::crc16_step(crc_q, delay0_q);
		len_wide = LW'(pos_q) - LW'(2);
	end

	// Build the result request
	always_comb begin
		result.valid        = 1'b0;
		result.kind         = hdlc_rx_pkg::KIND_PAYLOAD;
		result.payload_byte = '0;
		result.frame_length = '0;
		result.dropped      = 1'b0;
		if (octet.valid && pos_ge2) begin
			if (is_flag) begin
				result.valid        = 1'b1;
				result.kind         = (rx_check == crc_q) ? hdlc_rx_pkg::KIND_END_OK
					: hdlc_rx_pkg::KIND_END_BAD;
				result.frame_length = len_wide[hdlc_rx_pkg::LEN_W-1:0];
			end else if (!is_esc) begin
				result.valid        = 1'b1;
				result.payload_byte = delay0_q;
				result.dropped      = at_limit;
			end
		end
	end

	// Advance escape, position and CRC
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_q <= 1'b0;
			pos_q    <= '0;
			crc_q    <= hdlc_rx_pkg::CRC_INIT_RESET;
		end else if (step && octet.valid) begin
			if (is_flag) begin
				escape_q <= 1'b0;
				pos_q    <= '0;
				crc_q    <= crc_init;
			end else if (is_esc) begin
				escape_q <= 1'b1;
			end else begin
				escape_q <= 1'b0;
				if (at_limit) begin
					pos_q <= '0;
					crc_q <= crc_init;
				end else begin
					pos_q <= pos_q + PW'(1);
					if (pos_ge2) begin
						crc_q <= crc_next;
					end
				end
			end
		end
	end

	// Shift the delay line on every data octet
	always_ff @(posedge clk) begin
		if (step && octet.valid && !is_flag && !is_esc) begin
			delay0_q <= delay1_q;
			delay1_q <= ch;
		end
	end

endmodule

// ===== rtl/hdlc_frame_receiver.sv =====
// A taken line item passes the input register and the result register. Throughput: one
// line item per cycle while results are taken; the input register and the result
// register are separate stages, so with the input register empty an item is taken while
// a finished result waits. Each item's unstuff, unescape and CRC byte update sit in one
// stage between the two. Reset: arst_n clears all control state; configuration returns to
// byte mode, little-endian check value and a CRC start value of 0xFFFF.
// ----------------------------------------------------------------------------
// HDLC frame receiver
// Deframes an HDLC line stream, streams payload out and checks the CRC-16.
// ----------------------------------------------------------------------------
module hdlc_frame_receiver #(
	parameter int MAX_FRAME_BYTES = hdlc_rx_pkg::DEF_MAX_FRAME_BYTES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [1:0]                        cfg_index,
	input  logic [hdlc_rx_pkg::CFG_DATA_W-1:0] cfg_data,
	hdlc_rx_in_if.sink                        feed,
	hdlc_rx_out_if.source                     result
);

	logic        bit_mode_q;
	logic        crc_big_endian_q;
	logic [15:0] crc_init_q;

	logic        valid_s1;
	logic [7:0]  data_s1;

	logic        res_valid_q;
	logic [1:0]  kind_q;
	logic [7:0]  payload_q;
	logic [9:0]  length_q;
	logic        dropped_q;

	logic        advance;
	logic        step;

	hdlc_rx_pkg::octet_ev_t octet;
	hdlc_rx_pkg::result_t   res;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_mode_q       <= 1'b0;
			crc_big_endian_q <= 1'b0;
			crc_init_q       <= hdlc_rx_pkg::CRC_INIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				hdlc_rx_pkg::CFG_BIT_MODE:       bit_mode_q       <= cfg_data[0];
				hdlc_rx_pkg::CFG_CRC_BIG_ENDIAN: crc_big_endian_q <= cfg_data[0];
				hdlc_rx_pkg::CFG_CRC_INIT:       crc_init_q       <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Advance when the result register is free or being emptied
	assign advance    = !res_valid_q || result.ready;
	assign step       = valid_s1 && advance;
	assign feed.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (feed.ready) begin
			valid_s1 <= feed.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (feed.ready && feed.valid) begin
			data_s1 <= feed.data_in;
		end
	end

	hdlc_rx_unstuff u_unstuff (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.bit_mode (bit_mode_q),
		.data     (data_s1),
		.octet    (octet)
	);

	hdlc_rx_frame #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_frame (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.crc_big_endian (crc_big_endian_q),
		.crc_init       (crc_init_q),
		.octet          (octet),
		.result         (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= step && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.valid) begin
			kind_q    <= res.kind;
			payload_q <= res.payload_byte;
			length_q  <= res.frame_length;
			dropped_q <= res.dropped;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.kind         = kind_q;
	assign result.payload_byte = payload_q;
	assign result.frame_length = length_q;
	assign result.dropped      = dropped_q;

endmodule
